FILE: sv/css_pkg.sv
// Shared types, widths and event codes for the clock step scheduler.
`default_nettype none

package css_pkg;

    // Default configuration of the scheduler
    localparam int DEF_PULSES_PER_STEP = 6;
    localparam int DEF_MAX_SWING       = 5;
    localparam int DEF_STEP_LIMIT      = 64;

    // Fixed widths, sized for the full parameter ranges
    localparam int PHASE_W = 5;    // pulse phase, up to 23
    localparam int POS_W   = 7;    // step position, below a 7 bit step count
    localparam int SWING_W = 6;    // signed swing, up to +/-23
    localparam int CD_W    = 5;    // late step countdown, up to 23
    localparam int SUM_W   = 7;    // phase plus early amount
    localparam int CNT_W   = 7;    // step_count register
    localparam int OP_W    = 3;
    localparam int STEP_W  = 6;    // reported step index
    localparam int SNOW_W  = 4;    // reported swing

    localparam logic [CNT_W-1:0] STEP_COUNT_RESET = 7'd16;

    // Transport event codes
    typedef enum logic [OP_W-1:0] {
        OP_CLOCK      = 3'd0,
        OP_START      = 3'd1,
        OP_CONTINUE   = 3'd2,
        OP_STOP       = 3'd3,
        OP_SWING_DOWN = 3'd4,
        OP_SWING_UP   = 3'd5
    } css_op_t;

    // Transport and swing state
    typedef struct packed {
        logic                      running;
        logic [PHASE_W-1:0]        phase;
        logic [POS_W-1:0]          position;
        logic [POS_W-1:0]          last_played;
        logic signed [SWING_W-1:0] swing;
        logic                      pend_valid;
        logic [POS_W-1:0]          pend_step;
        logic [CD_W-1:0]           pend_count;
        logic                      early_valid;
        logic [POS_W-1:0]          early_step;
    } css_state_t;

    // One result transaction
    typedef struct packed {
        logic               play_valid;
        logic [STEP_W-1:0]  play_step;
        logic               notes_off;
        logic [SNOW_W-1:0]  swing_now;
        logic               running_now;
    } css_result_t;

    // Reset value of the state
    localparam css_state_t STATE_RESET = '{
        running:     1'b0,
        phase:       '0,
        position:    '0,
        last_played: '0,
        swing:       '0,
        pend_valid:  1'b0,
        pend_step:   '0,
        pend_count:  '0,
        early_valid: 1'b0,
        early_step:  '0
    };

endpackage

`default_nettype wire

FILE: sv/css_step_logic.sv
// Single-pass next-state and result logic for one transport event.
`default_nettype none

module css_step_logic
    import css_pkg::*;
#(
    parameter int PULSES_PER_STEP = DEF_PULSES_PER_STEP,
    parameter int MAX_SWING       = DEF_MAX_SWING,
    parameter int STEP_LIMIT      = DEF_STEP_LIMIT
)
(
    input  wire logic [OP_W-1:0]  op,
    input  wire logic [CNT_W-1:0] step_count,
    input  wire css_state_t       state,
    output css_state_t            state_next,
    output css_result_t           result
);

    localparam int MultMax = (PULSES_PER_STEP - 1 + MAX_SWING) / PULSES_PER_STEP;
    localparam logic signed [SWING_W-1:0] SwingMax = SWING_W'(MAX_SWING);
    localparam logic signed [SWING_W-1:0] SwingMin = -SWING_W'(MAX_SWING);
    localparam logic [PHASE_W-1:0] PhaseLast = PHASE_W'(PULSES_PER_STEP - 1);
    localparam logic [8:0] StepLim = 9'(STEP_LIMIT);

    logic [8:0]       count_ext;
    logic [POS_W-1:0] steps;

    // Clamp the step count to the step limit
    always_comb
    begin
        count_ext = 9'(step_count);
        steps     = (count_ext > StepLim) ? POS_W'(StepLim) : POS_W'(count_ext);
    end

    // Wrap position plus one at the step count
    function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos,
                                                  input logic [POS_W-1:0] cnt);
        logic [POS_W:0] n;
        begin
            n = {1'b0, pos} + (POS_W+1)'(1);
            next_pos = (n >= {1'b0, cnt}) ? '0 : POS_W'(n);
        end
    endfunction

    css_state_t       st;
    logic             play;
    logic [POS_W-1:0] play_pos;
    logic             notes;
    logic [SWING_W-1:0] early_amt;
    logic [SUM_W-1:0] early_sum;
    logic             early_hit;
    logic [POS_W-1:0] up;
    logic             swing_neg;
    logic             swing_pos;

    // Apply one event to the state
    always_comb
    begin
        st        = state;
        play      = 1'b0;
        play_pos  = '0;
        notes     = 1'b0;
        swing_neg = state.swing[SWING_W-1];
        swing_pos = !state.swing[SWING_W-1] && (state.swing != '0);
        early_amt = SWING_W'(-state.swing);
        early_sum = '0;
        early_hit = 1'b0;
        up        = '0;

        unique case (op)
            OP_CLOCK:
            begin
                if (state.running)
                begin
                    // advance the pulse phase
                    st.phase = (state.phase == PhaseLast) ? '0 : state.phase + PHASE_W'(1);

                    // release a late step whose countdown runs out
                    if (state.pend_valid)
                    begin
                        if (state.pend_count <= CD_W'(1))
                        begin
                            play          = 1'b1;
                            play_pos      = state.pend_step;
                            st.pend_valid = 1'b0;
                            st.pend_step  = '0;
                            st.pend_count = '0;
                        end
                        else
                        begin
                            st.pend_count = state.pend_count - CD_W'(1);
                        end
                    end

                    // play an odd step early under negative swing
                    early_sum = SUM_W'(st.phase) + SUM_W'(early_amt);
                    for (int k = 0; k <= MultMax; k++)
                    begin
                        if (early_sum == SUM_W'(k * PULSES_PER_STEP))
                            early_hit = 1'b1;
                    end
                    up = next_pos(state.position, steps);
                    if (swing_neg && !state.early_valid && steps != '0 && early_hit
                        && up[0])
                    begin
                        play           = 1'b1;
                        play_pos       = up;
                        st.early_valid = 1'b1;
                        st.early_step  = up;
                    end

                    // step boundary
                    if (st.phase == '0 && steps != '0)
                    begin
                        st.position = next_pos(state.position, steps);
                        if (st.early_valid && st.early_step == st.position)
                        begin
                            st.early_valid = 1'b0;
                            st.early_step  = '0;
                        end
                        else if (swing_pos && st.position[0])
                        begin
                            st.pend_valid = 1'b1;
                            st.pend_step  = st.position;
                            st.pend_count = CD_W'(state.swing);
                        end
                        else
                        begin
                            play     = 1'b1;
                            play_pos = st.position;
                        end
                    end
                end
            end
            OP_START, OP_STOP:
            begin
                st         = STATE_RESET;
                st.swing   = state.swing;
                st.running = (op == OP_START);
                notes      = 1'b1;
            end
            OP_CONTINUE:
            begin
                st             = STATE_RESET;
                st.running     = 1'b1;
                st.phase       = state.phase;
                st.position    = state.last_played;
                st.last_played = state.last_played;
                st.swing       = state.swing;
            end
            OP_SWING_DOWN, OP_SWING_UP:
            begin
                st             = STATE_RESET;
                st.running     = state.running;
                st.phase       = state.phase;
                st.position    = state.position;
                st.last_played = state.last_played;
                if (op == OP_SWING_DOWN && state.swing > SwingMin)
                    st.swing = state.swing - SWING_W'(1);
                else if (op == OP_SWING_UP && state.swing < SwingMax)
                    st.swing = state.swing + SWING_W'(1);
                else
                    st.swing = state.swing;
            end
            default:
            begin
                st = state;
            end
        endcase

        // the last play of the event wins
        if (play)
            st.last_played = play_pos;

        state_next         = st;
        result.play_valid  = play;
        result.play_step   = play ? STEP_W'(play_pos) : '0;
        result.notes_off   = notes;
        result.swing_now   = SNOW_W'(st.swing);
        result.running_now = st.running;
    end

endmodule

`default_nettype wire

FILE: sv/clock_step_scheduler_with_swing.sv
// Top level of the transport clock step scheduler with swing.
// The accepted event is held in the input register; its result loads into the
// result register once that register is empty or is being read out.
// Throughput: one event per cycle, set by the single-pass step rule; the input
// stalls only while the input register is full and the result waits under out_stall.
// Reset: asynchronous, clears the transport state and swing, step_count returns to 16.
`default_nettype none

module clock_step_scheduler_with_swing
    import css_pkg::*;
#(
    parameter int PULSES_PER_STEP = DEF_PULSES_PER_STEP,
    parameter int MAX_SWING       = DEF_MAX_SWING,
    parameter int STEP_LIMIT      = DEF_STEP_LIMIT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_count_we,
    input  wire logic [CNT_W-1:0]  step_count_wdata,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [OP_W-1:0]   event_opcode,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   play_valid,
    output logic [STEP_W-1:0]      play_step,
    output logic                   notes_off,
    output logic signed [SNOW_W-1:0] swing_now,
    output logic                   running_now
);

    logic [CNT_W-1:0] step_count_reg;
    logic [OP_W-1:0]  op_reg;
    logic             stage_valid_reg;
    logic             stage_valid_next;
    css_state_t       state_reg;
    css_state_t       state_next;
    css_result_t      result;
    css_result_t      out_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;
    logic             in_accept;
    logic             advance;

    // Handshake between input register and result register
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = stage_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign advance   = stage_valid_reg && out_free;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // Hold the step count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_count_reg <= STEP_COUNT_RESET;
        else if (step_count_we)
            step_count_reg <= step_count_wdata;
    end

    // Compute the next state and result of the registered event
    css_step_logic #(
        .PULSES_PER_STEP(PULSES_PER_STEP),
        .MAX_SWING      (MAX_SWING),
        .STEP_LIMIT     (STEP_LIMIT)
    ) u_step (
        .op        (op_reg),
        .step_count(step_count_reg),
        .state     (state_reg),
        .state_next(state_next),
        .result    (result)
    );

    // Advance control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= STATE_RESET;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Capture input and result payloads
    always_ff @(posedge clk)
    begin
        if (in_accept)
            op_reg <= event_opcode;
        if (advance)
            out_reg <= result;
    end

    // Drive the result ports
    assign out_valid   = out_valid_reg;
    assign play_valid  = out_reg.play_valid;
    assign play_step   = out_reg.play_step;
    assign notes_off   = out_reg.notes_off;
    assign swing_now   = out_reg.swing_now;
    assign running_now = out_reg.running_now;

    // Late and early steps never coexist
    a_pend_early_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.pend_valid && state_reg.early_valid))
        else $error("late and early step both outstanding");

    // A late step only exists under positive swing
    a_pend_swing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pend_valid |-> (!state_reg.swing[SWING_W-1] && state_reg.swing != '0))
        else $error("late step without positive swing");

    // Phase stays below one step
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase < PHASE_W'(PULSES_PER_STEP))
        else $error("pulse phase out of range");

    // A played step implies a running transport and no notes off
    a_play_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.play_valid) |-> (out_reg.running_now && !out_reg.notes_off))
        else $error("step played while stopped or on notes off");

    // A result transaction follows each advance of the input register
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after advance");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the transport clock step scheduler with swing.
`timescale 1ns / 1ps

module testbench
    import css_pkg::*;
();

    localparam int PPS         = DEF_PULSES_PER_STEP;
    localparam int SWING_LIMIT = DEF_MAX_SWING;
    localparam int STEP_CAP    = DEF_STEP_LIMIT;
    localparam int WATCHDOG    = 2000;
    localparam int DRAIN       = 8;
    localparam int LONG_ITEMS  = 300;
    localparam int PHASE_ITEMS = 35;

    // Codes outside the defined set; the block must treat them as no-ops
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     step_count_we = 1'b0;
    logic [CNT_W-1:0]         step_count_wdata = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          event_opcode = OP_CLOCK;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     play_valid;
    logic [STEP_W-1:0]        play_step;
    logic                     notes_off;
    logic signed [SNOW_W-1:0] swing_now;
    logic                     running_now;

    clock_step_scheduler_with_swing dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_count_we    (step_count_we),
        .step_count_wdata (step_count_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .event_opcode     (event_opcode),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .play_valid       (play_valid),
        .play_step        (play_step),
        .notes_off        (notes_off),
        .swing_now        (swing_now),
        .running_now      (running_now)
    );

    // Transport state mirrored by the predictor
    logic                      sch_running;
    logic [PHASE_W-1:0]        sch_phase;
    logic [POS_W-1:0]          sch_pos;
    logic [POS_W-1:0]          sch_last;
    logic signed [SWING_W-1:0] sch_swing;
    logic                      sch_pend;
    logic [POS_W-1:0]          sch_pend_step;
    logic [CD_W-1:0]           sch_pend_cnt;
    logic                      sch_early;
    logic [POS_W-1:0]          sch_early_step;
    logic [CNT_W-1:0]          sch_step_count;

    logic [OP_W-1:0] event_backlog[$];
    css_result_t     due_results[$];
    int              mismatch_count = 0;
    bit              ev_accepted = 1'b0;
    int              idle_cycles = 0;

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Random idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    function automatic void drop_swing_work();
        sch_pend       = 1'b0;
        sch_pend_step  = '0;
        sch_pend_cnt   = '0;
        sch_early      = 1'b0;
        sch_early_step = '0;
    endfunction

    function automatic void rewind_transport();
        sch_phase = '0;
        sch_pos   = '0;
        sch_last  = '0;
        drop_swing_work();
    endfunction

    function automatic logic [POS_W-1:0] wrap_next(input logic [POS_W-1:0] pos, input int steps);
        int n;
        n = int'(pos) + 1;
        return (n >= steps) ? '0 : POS_W'(n);
    endfunction

    function automatic void sound_step(inout css_result_t r, input logic [POS_W-1:0] s);
        r.play_valid = 1'b1;
        r.play_step  = s[STEP_W-1:0];
        sch_last     = s;
    endfunction

    // Apply one transport event to the mirrored state and return its result
    function automatic css_result_t advance_transport(input logic [OP_W-1:0] op);
        css_result_t     r;
        int              steps;
        int              sw;
        int              ph;
        logic [POS_W-1:0] up;
        r     = '0;
        steps = (int'(sch_step_count) > STEP_CAP) ? STEP_CAP : int'(sch_step_count);
        sw    = sch_swing;
        case (op)
            OP_CLOCK:
            begin
                if (sch_running)
                begin
                    ph        = (int'(sch_phase) + 1) % PPS;
                    sch_phase = PHASE_W'(ph);
                    // Release a late step when its countdown runs out
                    if (sch_pend)
                    begin
                        if (sch_pend_cnt <= 1)
                        begin
                            sound_step(r, sch_pend_step);
                            sch_pend      = 1'b0;
                            sch_pend_step = '0;
                            sch_pend_cnt  = '0;
                        end
                        else
                            sch_pend_cnt = sch_pend_cnt - 1'b1;
                    end
                    // Play an odd step early under negative swing
                    if (sw < 0 && !sch_early && steps > 0)
                    begin
                        if ((ph - sw) % PPS == 0)
                        begin
                            up = wrap_next(sch_pos, steps);
                            if (up[0])
                            begin
                                sound_step(r, up);
                                sch_early      = 1'b1;
                                sch_early_step = up;
                            end
                        end
                    end
                    // Step boundary
                    if (ph == 0 && steps > 0)
                    begin
                        sch_pos = wrap_next(sch_pos, steps);
                        if (sch_early && sch_early_step == sch_pos)
                        begin
                            sch_early      = 1'b0;
                            sch_early_step = '0;
                        end
                        else if (sw > 0 && sch_pos[0])
                        begin
                            sch_pend      = 1'b1;
                            sch_pend_step = sch_pos;
                            sch_pend_cnt  = CD_W'(sw);
                        end
                        else
                            sound_step(r, sch_pos);
                    end
                end
            end
            OP_START:
            begin
                sch_running = 1'b1;
                rewind_transport();
                r.notes_off = 1'b1;
            end
            OP_CONTINUE:
            begin
                sch_running = 1'b1;
                sch_pos     = sch_last;
                drop_swing_work();
            end
            OP_STOP:
            begin
                sch_running = 1'b0;
                rewind_transport();
                r.notes_off = 1'b1;
            end
            OP_SWING_DOWN:
            begin
                if (sw > -SWING_LIMIT)
                    sch_swing = sch_swing - SWING_W'(1);
                drop_swing_work();
            end
            OP_SWING_UP:
            begin
                if (sw < SWING_LIMIT)
                    sch_swing = sch_swing + SWING_W'(1);
                drop_swing_work();
            end
            default:
            begin
            end
        endcase
        r.swing_now   = sch_swing[SNOW_W-1:0];
        r.running_now = sch_running;
        return r;
    endfunction

    // Queue one run of the transport: swing moves, start or resume, pulses, maybe stop
    task automatic queue_segment(input bit resume, input bit long_run, inout int count);
        int              moves;
        int              pulses;
        logic [OP_W-1:0] dir;
        moves = ($urandom_range(0, 99) < 60) ? $urandom_range(1, 11) : 0;
        dir   = $urandom_range(0, 1) ? OP_SWING_UP : OP_SWING_DOWN;
        repeat (moves) event_backlog.push_back(dir);
        if (resume || long_run || $urandom_range(0, 99) < 30)
            event_backlog.push_back(OP_CONTINUE);
        else
            event_backlog.push_back(OP_START);
        pulses = long_run ? $urandom_range(30, 90) : $urandom_range(4, 40);
        repeat (pulses)
        begin
            if ($urandom_range(0, 99) < 5)
                event_backlog.push_back(OP_W'($urandom_range(0, 7)));
            else
                event_backlog.push_back(OP_CLOCK);
        end
        count += moves + 1 + pulses;
        if (!long_run && $urandom_range(0, 99) < 25)
        begin
            event_backlog.push_back(OP_STOP);
            count++;
        end
    endtask

    // Hold until every queued event is accepted and every result has come back
    task automatic wait_idle();
        while (event_backlog.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
    endtask

    // Driver: advance the event stream at the falling edge
    int send_gap = 0;
    int burst_left = 0;
    always @(negedge clk)
    begin
        if (!in_valid || ev_accepted)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (event_backlog.size() != 0)
            begin
                event_opcode <= event_backlog.pop_front();
                in_valid     <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                    send_gap = 0;
                end
                else if ($urandom_range(0, 99) < 3)
                begin
                    burst_left = $urandom_range(20, 60);
                    send_gap   = 0;
                end
                else if ($urandom_range(0, 99) < 50)
                    send_gap = 0;
                else
                    send_gap = idle_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result-side backpressure
    int stall_left = 0;
    int quiet_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 99) < 30)
                stall_left = idle_len();
            else if ($urandom_range(0, 99) < 5)
                quiet_left = $urandom_range(20, 80);
        end
    end

    // Monitor: predict on accepted events, check accepted results
    always @(posedge clk)
    begin
        css_result_t want;
        ev_accepted = rst_n && in_valid && !in_stall;
        if (ev_accepted)
            due_results.push_back(advance_transport(event_opcode));
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("result transaction with no event pending");
                mismatch_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (play_valid !== want.play_valid)
                begin
                    $error("play_valid: expected %0d, actual %0d", want.play_valid, play_valid);
                    mismatch_count++;
                end
                if (play_step !== want.play_step)
                begin
                    $error("play_step: expected %0d, actual %0d", want.play_step, play_step);
                    mismatch_count++;
                end
                if (notes_off !== want.notes_off)
                begin
                    $error("notes_off: expected %0d, actual %0d", want.notes_off, notes_off);
                    mismatch_count++;
                end
                if (swing_now !== want.swing_now)
                begin
                    $error("swing_now: expected %0d, actual %0d",
                           $signed(want.swing_now), swing_now);
                    mismatch_count++;
                end
                if (running_now !== want.running_now)
                begin
                    $error("running_now: expected %0d, actual %0d",
                           want.running_now, running_now);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus: reset, directed events, then one random phase per step count
    initial
    begin
        logic [CNT_W-1:0] counts[8];
        int               added;
        bit               long_run;
        int               budget;
        counts = '{7'd2, 7'd0, 7'd64, 7'd5, 7'd1, 7'd127, 7'd3, 7'd16};

        sch_running    = 1'b0;
        sch_swing      = '0;
        sch_step_count = STEP_COUNT_RESET;
        rewind_transport();

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: ignored pulse, unused codes, late step at full positive swing
        event_backlog.push_back(OP_CLOCK);
        event_backlog.push_back(OP_UNUSED_A);
        event_backlog.push_back(OP_UNUSED_B);
        event_backlog.push_back(OP_START);
        repeat (6) event_backlog.push_back(OP_SWING_UP);
        repeat (11) event_backlog.push_back(OP_CLOCK);
        event_backlog.push_back(OP_STOP);
        event_backlog.push_back(OP_CONTINUE);
        event_backlog.push_back(OP_SWING_DOWN);
        event_backlog.push_back(OP_STOP);

        foreach (counts[i])
        begin
            // Pause the sender until the pipeline is empty, then reprogram
            wait_idle();
            repeat (2) @(negedge clk);
            step_count_we    = 1'b1;
            step_count_wdata = counts[i];
            sch_step_count   = counts[i];
            @(negedge clk);
            step_count_we    = 1'b0;

            long_run = (counts[i] == 7'd64);
            budget   = long_run ? LONG_ITEMS : PHASE_ITEMS;
            added    = 0;
            // Resume first so a shrunk pattern sees a position beyond its end
            queue_segment(1'b1, long_run, added);
            while (added < budget)
                queue_segment(1'b0, long_run, added);
        end

        wait_idle();
        repeat (DRAIN) @(negedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: clock_step_scheduler_with_swing.f
sv/css_pkg.sv
sv/css_step_logic.sv
sv/clock_step_scheduler_with_swing.sv
verif/testbench.sv
